FILE: rtl/swq_pkg.sv
// Shared types and constants for the sleep wait queue.
// Depends on nothing; imported by sleep_wait_queue_by_wake_time.
package swq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TaskW         = 8;
  localparam int unsigned TimeW         = 31;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned OccW          = 5;

  // request codes
  localparam logic ReqPush = 1'b0;
  localparam logic ReqPop  = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  // one stored queue entry
  typedef struct packed {
    logic [TaskW-1:0] task_id;
    logic [TimeW-1:0] wake_time;
  } swq_entry_t;

endpackage

FILE: rtl/sleep_wait_queue_by_wake_time.sv
// Sleep wait queue: tasks held in ascending wake-time order in a ring memory; needs swq_pkg.
// Full push, empty pop and push into an empty queue go straight to the result; other pushes
// walk back from the tail, shifting each entry with a later wake time up (one compare a cycle).
// One request at a time, taken once the sequencer is idle (even while the last result still
// waits at the output register).
// Reset (async, active low) empties the queue at once; the slot memory is not cleared.
module sleep_wait_queue_by_wake_time #(
  parameter int unsigned QUEUE_DEPTH = swq_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [swq_pkg::TaskW-1:0]    task_id_i,
  input  logic [swq_pkg::TimeW-1:0]    wake_time_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [swq_pkg::StatusW-1:0]  status_o,
  output logic [swq_pkg::TaskW-1:0]    out_task_id_o,
  output logic [swq_pkg::TimeW-1:0]    out_wake_time_o,
  output logic [swq_pkg::OccW-1:0]     occupancy_o
);
  import swq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CMP,
    S_PUSH_WR,
    S_POP_RD,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] pos_q, pos_d;
  swq_entry_t    key_q, key_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  swq_entry_t    res_entry_q, res_entry_d;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  swq_entry_t         out_entry_q, out_entry_d;
  logic [OccW-1:0]    out_occ_q, out_occ_d;

  // ring memory and its ports
  swq_entry_t mem_q [QUEUE_DEPTH];
  swq_entry_t rd_data_q;
  logic       rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  swq_entry_t wr_data;

  logic accept;
  logic out_free;
  logic later;

  // logical slot to ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(idx);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // comparator: held entry leaves after the new one
  assign later = (rd_data_q.wake_time > key_q.wake_time);

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_occ_d    = out_occ_q;
    rd_en        = 1'b0;
    rd_addr      = phys(head_q, pos_q - CW'(1));
    wr_en        = 1'b0;
    wr_addr      = phys(head_q, pos_q);
    wr_data      = key_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d.task_id   = task_id_i;
          key_d.wake_time = wake_time_i;
          res_status_d    = StatusOk;
          res_entry_d     = '0;
          if (req_type_i == ReqPop) begin
            if (count_q == '0) begin
              res_status_d = StatusEmpty;
              state_d      = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_POP_RD;
            end
          end else begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              res_status_d = StatusFull;
              state_d      = S_RESP;
            end else if (count_q == '0) begin
              wr_en             = 1'b1;
              wr_addr           = head_q;
              wr_data.task_id   = task_id_i;
              wr_data.wake_time = wake_time_i;
              count_d           = count_q + CW'(1);
              state_d           = S_RESP;
            end else begin
              rd_en   = 1'b1;
              rd_addr = phys(head_q, count_q - CW'(1));
              pos_d   = count_q;
              state_d = S_PUSH_CMP;
            end
          end
        end
      end

      // one held entry per cycle: shift it up or drop the new one in
      S_PUSH_CMP: begin
        wr_en = 1'b1;
        if (later) begin
          wr_data = rd_data_q;
          pos_d   = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = S_PUSH_WR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_q, pos_q - CW'(2));
          end
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_RESP;
        end
      end

      // new entry lands at the front
      S_PUSH_WR: begin
        wr_en   = 1'b1;
        count_d = count_q + CW'(1);
        state_d = S_RESP;
      end

      S_POP_RD: begin
        res_entry_d = rd_data_q;
        head_d      = phys(head_q, CW'(1));
        count_d     = count_q - CW'(1);
        state_d     = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_entry_d  = res_entry_q;
          out_occ_d    = OccW'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      head_q       <= '0;
      pos_q        <= '0;
      key_q        <= '0;
      res_status_q <= StatusOk;
      res_entry_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StatusOk;
      out_entry_q  <= '0;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      head_q       <= head_d;
      pos_q        <= pos_d;
      key_q        <= key_d;
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_entry_q  <= out_entry_d;
      out_occ_q    <= out_occ_d;
    end
  end

  // slot memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_task_id_o   = out_entry_q.task_id;
  assign out_wake_time_o = out_entry_q.wake_time;
  assign occupancy_o     = out_occ_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == ReqPop) && (count_q == '0)
    |=> (state_q == S_RESP) && (res_status_q == StatusEmpty))
    else $error("pop from empty queue not reported");

  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH_CMP) |-> (pos_q != '0) && (pos_q <= count_q))
    else $error("insertion scan position out of range");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && !accept |=> $stable(count_q) && $stable(head_q))
    else $error("queue changed without a request");
`endif

endmodule

FILE: tb/sleep_wait_queue_by_wake_time_test.sv
// Self-checking testbench for sleep_wait_queue_by_wake_time: a scoreboard class keeps its own
// wake-time ordered copy of the queue and checks every pop/push result in request order.
// Depends on swq_pkg and the sleep_wait_queue_by_wake_time RTL.
module sleep_wait_queue_by_wake_time_test;
  import swq_pkg::*;

  localparam int unsigned Depth      = QueueDepthDef;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainWait  = 24;
  localparam int unsigned PhaseItems = 460;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // one expected result of a request
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [TaskW-1:0]   task_id;
    logic [TimeW-1:0]   wake_time;
    logic [OccW-1:0]    occupancy;
  } queue_result_t;

  // Scoreboard: tracks the sorted queue and holds results still owed by the block
  class wake_queue_scoreboard;
    logic [TaskW-1:0] held_task[Depth];
    logic [TimeW-1:0] held_time[Depth];
    int unsigned      held_count;
    queue_result_t    owed_results[$];
    int unsigned      mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // update the sorted copy for one accepted request and note its result
    function void note_request(logic req, logic [TaskW-1:0] tid, logic [TimeW-1:0] t);
      queue_result_t res;
      int unsigned   pos;
      int unsigned   k;
      res = '0;
      if (req == ReqPush) begin
        if (held_count >= Depth) begin
          res.status = StatusFull;
        end else begin
          // later entries (strictly greater time) move up; equal times stay ahead
          pos = held_count;
          while (pos > 0 && held_time[pos-1] > t) begin
            held_task[pos] = held_task[pos-1];
            held_time[pos] = held_time[pos-1];
            pos--;
          end
          held_task[pos] = tid;
          held_time[pos] = t;
          held_count++;
          res.status = StatusOk;
        end
      end else begin
        if (held_count == 0) begin
          res.status = StatusEmpty;
        end else begin
          res.status    = StatusOk;
          res.task_id   = held_task[0];
          res.wake_time = held_time[0];
          for (k = 1; k < held_count; k++) begin
            held_task[k-1] = held_task[k];
            held_time[k-1] = held_time[k];
          end
          held_count--;
        end
      end
      res.occupancy = OccW'(held_count);
      owed_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result from the block with the oldest owed result
    function void check_result(logic [StatusW-1:0] st, logic [TaskW-1:0] tid,
                               logic [TimeW-1:0] t, logic [OccW-1:0] occ);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0h task %0h time %0h",
                 $time, st, tid, t);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        compare_field("status", 64'(want.status), 64'(st));
        compare_field("task_id", 64'(want.task_id), 64'(tid));
        compare_field("wake_time", 64'(want.wake_time), 64'(t));
        compare_field("occupancy", 64'(want.occupancy), 64'(occ));
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               req_type_i  = ReqPush;
  logic [TaskW-1:0]   task_id_i   = '0;
  logic [TimeW-1:0]   wake_time_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [StatusW-1:0] status_o;
  logic [TaskW-1:0]   out_task_id_o;
  logic [TimeW-1:0]   out_wake_time_o;
  logic [OccW-1:0]    occupancy_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;
  wake_queue_scoreboard sb   = new();

  sleep_wait_queue_by_wake_time #(
    .QUEUE_DEPTH(Depth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .task_id_i      (task_id_i),
    .wake_time_i    (wake_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_task_id_o  (out_task_id_o),
    .out_wake_time_o(out_wake_time_o),
    .occupancy_o    (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(req_type_i, task_id_i, wake_time_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(status_o, out_task_id_o, out_wake_time_o, occupancy_o);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // hand one request to the block, with an optional random gap first
  task automatic send_request(logic req, logic [TaskW-1:0] tid, logic [TimeW-1:0] t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    task_id_i   <= tid;
    wake_time_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off new requests until every owed result is back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // small times often so equal keys are common, plus both extremes and full range
  function automatic logic [TimeW-1:0] random_wake_time();
    logic [TimeW-1:0] t;
    case ($urandom_range(9))
      0: t = '0;
      1: t = TimeMax;
      2, 3, 4, 5: t = TimeW'($urandom_range(15));
      default: t = TimeW'($urandom);
    endcase
    return t;
  endfunction

  // random traffic in bursts that lean toward filling, draining or balance
  task automatic run_random_phase(int unsigned n);
    int unsigned sent;
    int unsigned burst_left;
    int unsigned push_pct;
    logic        req;
    sent       = 0;
    burst_left = 0;
    push_pct   = 50;
    wait_results();
    while (sent < n) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      req = ($urandom_range(99) < push_pct) ? ReqPush : ReqPop;
      send_request(req, TaskW'($urandom), random_wake_time());
      sent++;
      burst_left--;
      if ($urandom_range(149) == 0) wait_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, extreme ids and times, equal keys, fill, full push
    send_idle_pct = 30;
    recv_idle_pct = 52;
    send_request(ReqPop, 8'h5A, TimeMax);
    send_request(ReqPush, 8'h00, TimeMax);
    send_request(ReqPush, 8'hFF, '0);
    send_request(ReqPush, 8'h11, 31'd100);
    send_request(ReqPush, 8'h12, 31'd100);
    send_request(ReqPush, 8'h13, 31'd100);
    send_request(ReqPush, 8'h14, 31'd50);
    send_request(ReqPush, 8'h15, TimeMax);
    send_request(ReqPush, 8'h16, '0);
    for (int unsigned i = 0; i < 8; i++) begin
      send_request(ReqPush, 8'hA0 + TaskW'(i), 31'h5555_5555 ^ TimeW'(i));
    end
    send_request(ReqPush, 8'hFF, '0);
    repeat (3) send_request(ReqPop, 8'hFF, TimeMax);

    // random traffic with three idling patterns
    run_random_phase(PhaseItems);
    send_idle_pct = 52;
    recv_idle_pct = 30;
    run_random_phase(PhaseItems);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(PhaseItems);

    wait_results();
    repeat (DrainWait) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
